/* src/pru_pkg.sv */
// package for the pixel replicate upscaler: constants, codes and register indexes
`default_nettype none
package pru_pkg;

	localparam int LINE_PIXELS_DEF = 2048;
	localparam int MAX_SCALE_DEF   = 100;

	localparam int SCALE_REG_W = 7;
	localparam int WIDTH_REG_W = 12;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_ADDR_W  = 1;
	localparam int PIX_W       = 24;

	localparam logic [SCALE_REG_W-1:0] SCALE_RESET = 7'd1;
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 12'd1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_SCALE_FACTOR = 1'b0,
		REG_ROW_WIDTH    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_PIXEL   = 2'd0,
		ST_NOT_RDY = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_PULL = 1'b1
	} cmd_t;

endpackage
`default_nettype wire

/* src/pixel_replicate_upscaler_top.sv */
// top level of the pixel replicate upscaler: line buffer memory, replay counters, output register
//
// channel   direction  handshake               payload
// s_axis    in         s_tvalid / s_tready     s_tdata = red, green, blue; s_tuser = cmd
// m_axis    out        m_tvalid / m_tready     m_tdata = red, green, blue, pad, group_end;
//                                              m_tuser = status; m_tlast = row_end
// cfg       in         cfg_we                  cfg_addr, cfg_wdata
//
// one transaction per clock in and out while the output is not stalled; a pull result is
// registered first by the line buffer read, then by the output register
// the line buffer is one single-port memory, written by pushes and read by pulls
// arst_n clears counters and pipeline valids; line buffer contents stay unknown until written
// a stalled output holds the pipeline; s_tready falls only when both stages are occupied
`default_nettype none
module pixel_replicate_upscaler_top
	import pru_pkg::*;
#(
	parameter int LINE_PIXELS = LINE_PIXELS_DEF,
	parameter int MAX_SCALE   = MAX_SCALE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [23:0]           s_tdata,   // red_in, green_in, blue_in
	input  wire logic                  s_tuser,   // cmd
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [31:0]                m_tdata,   // red_out, green_out, blue_out, pad_bytes, group_end
	output logic [1:0]                 m_tuser,   // status
	output logic                       m_tlast,   // row_end
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW  = $clog2(LINE_PIXELS);
	localparam int FW  = $clog2(LINE_PIXELS + 1);
	localparam int CW  = (FW > WIDTH_REG_W) ? FW : WIDTH_REG_W;
	localparam int SW  = $clog2(MAX_SCALE + 1);
	localparam int RW  = (SW > 1) ? SW : 1;

	logic [SCALE_REG_W-1:0] scale_q;
	logic [WIDTH_REG_W-1:0] width_q;

	logic [FW-1:0] fill_q;
	logic [AW-1:0] col_q;
	logic [RW-1:0] crep_q;
	logic [RW-1:0] rrep_q;

	logic [PIX_W-1:0] line_mem [LINE_PIXELS];
	logic [PIX_W-1:0] rd_data_q;

	logic          valid_s1;
	status_t       status_s1;
	logic          rend_s1;
	logic [1:0]    pad_s1;
	logic          gend_s1;

	logic          out_valid_q;
	status_t       out_status_q;
	logic [PIX_W-1:0] out_pix_q;
	logic          out_rend_q;
	logic [1:0]    out_pad_q;
	logic          out_gend_q;

	logic [CW-1:0] width_ext;
	logic [FW-1:0] eff_width;
	logic [RW-1:0] eff_scale;
	logic          full;
	logic          accept;
	logic          is_pull;
	logic          advance_out;
	logic          s1_free;
	logic          last_copy;
	logic          last_col;
	logic          last_row;
	logic          push_ok;
	logic          pull_ok;

	// effective register values
	always_comb begin
		width_ext = CW'(width_q);
		if (width_q == '0)
			eff_width = FW'(1);
		else if (width_ext > CW'(LINE_PIXELS))
			eff_width = FW'(LINE_PIXELS);
		else
			eff_width = FW'(width_ext);

		if (scale_q == '0)
			eff_scale = RW'(1);
		else if (scale_q > SCALE_REG_W'(MAX_SCALE))
			eff_scale = RW'(MAX_SCALE);
		else
			eff_scale = RW'(scale_q);
	end

	assign advance_out = !out_valid_q || m_tready;
	assign s1_free     = !valid_s1 || advance_out;
	assign s_tready    = s1_free;
	assign accept      = s_tvalid && s_tready;
	assign is_pull     = (s_tuser == CMD_PULL);
	assign full        = (fill_q >= eff_width);
	assign push_ok     = accept && !is_pull && !full;
	assign pull_ok     = accept && is_pull && full;

	assign last_copy = ((RW+1)'(crep_q) + (RW+1)'(1)) >= (RW+1)'(eff_scale);
	assign last_col  = ((FW+1)'(col_q) + (FW+1)'(1)) >= (FW+1)'(eff_width);
	assign last_row  = ((RW+1)'(rrep_q) + (RW+1)'(1)) >= (RW+1)'(eff_scale);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_SCALE_FACTOR: scale_q <= cfg_wdata[SCALE_REG_W-1:0];
				REG_ROW_WIDTH:    width_q <= cfg_wdata[WIDTH_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// line buffer
	always_ff @(posedge clk) begin
		if (push_ok)
			line_mem[fill_q[AW-1:0]] <= s_tdata;
		if (pull_ok)
			rd_data_q <= line_mem[col_q];
	end

	// fill and replay counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			col_q  <= '0;
			crep_q <= '0;
			rrep_q <= '0;
		end else if (push_ok) begin
			fill_q <= fill_q + FW'(1);
		end else if (pull_ok) begin
			if (!last_copy) begin
				crep_q <= crep_q + RW'(1);
			end else begin
				crep_q <= '0;
				if (!last_col) begin
					col_q <= col_q + AW'(1);
				end else begin
					col_q <= '0;
					if (last_row) begin
						rrep_q <= '0;
						fill_q <= '0;
					end else begin
						rrep_q <= rrep_q + RW'(1);
					end
				end
			end
		end
	end

	// stage 1: result control while the buffer read is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept && (is_pull || full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rend_s1 <= 1'b0;
			pad_s1  <= 2'd0;
			gend_s1 <= 1'b0;
			if (!is_pull)
				status_s1 <= ST_REFUSED;
			else if (!full)
				status_s1 <= ST_NOT_RDY;
			else begin
				status_s1 <= ST_PIXEL;
				if (last_copy && last_col) begin
					rend_s1 <= 1'b1;
					pad_s1  <= 2'(eff_width[1:0] * 2'(eff_scale));
					gend_s1 <= last_row;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_out && valid_s1) begin
			out_status_q <= status_s1;
			out_pix_q    <= (status_s1 == ST_PIXEL) ? rd_data_q : '0;
			out_rend_q   <= rend_s1;
			out_pad_q    <= pad_s1;
			out_gend_q   <= gend_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_rend_q;
	assign m_tdata  = {5'd0, out_gend_q, out_pad_q, out_pix_q};

endmodule
`default_nettype wire

/* bench/pixel_replicate_upscaler_top_tb.sv */
// testbench for the pixel replicate upscaler: directed and random pushes and pulls checked against a local predictor
`default_nettype none
module pixel_replicate_upscaler_top_tb;
	import pru_pkg::*;

	typedef struct packed {
		status_t     status;
		logic        row_end;
		logic        group_end;
		logic [1:0]  pad;
		logic [23:0] rgb;   // red, green, blue from the lowest bit up
	} out_pixel_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BEAT
	} rx_mode_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata   = '0;  // red_in, green_in, blue_in
	logic                  s_tuser   = CMD_PUSH;  // cmd
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [31:0]           m_tdata;   // red_out, green_out, blue_out, pad_bytes, group_end
	logic [1:0]            m_tuser;   // status
	logic                  m_tlast;   // row_end
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = REG_SCALE_FACTOR;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// predictor state
	logic [SCALE_REG_W-1:0] scale_reg = SCALE_RESET;
	logic [WIDTH_REG_W-1:0] width_reg = WIDTH_RESET;
	logic [23:0]            line_mem [LINE_PIXELS_DEF];
	int unsigned            loaded_pixels = 0;
	int unsigned            replay_col    = 0;
	int unsigned            copy_count    = 0;
	int unsigned            row_count     = 0;

	out_pixel_t  out_pixels_due[$];
	int unsigned mismatch_count = 0;
	int unsigned burst_left     = 0;
	rx_mode_t    rx_mode        = RX_OPEN;
	int unsigned rx_hold        = 0;

	pixel_replicate_upscaler_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned active_scale();
		if (scale_reg == 0) return 1;
		if (scale_reg > MAX_SCALE_DEF) return MAX_SCALE_DEF;
		return scale_reg;
	endfunction

	function automatic int unsigned active_width();
		if (width_reg == 0) return 1;
		if (width_reg > LINE_PIXELS_DEF) return LINE_PIXELS_DEF;
		return width_reg;
	endfunction

	task automatic replicate_step(input cmd_t c, input logic [23:0] rgb);
		int unsigned w;
		int unsigned s;
		int unsigned addr;
		out_pixel_t  r;
		w = active_width();
		s = active_scale();
		r = '0;
		if (c == CMD_PUSH) begin
			if (loaded_pixels >= w) begin
				r.status = ST_REFUSED;
				out_pixels_due.push_back(r);
			end else begin
				line_mem[loaded_pixels] = rgb;
				loaded_pixels++;
			end
		end else if (loaded_pixels < w) begin
			r.status = ST_NOT_RDY;
			out_pixels_due.push_back(r);
		end else begin
			addr = (replay_col < LINE_PIXELS_DEF) ? replay_col : LINE_PIXELS_DEF - 1;
			r.status = ST_PIXEL;
			r.rgb = line_mem[addr];
			if (copy_count + 1 < s) begin
				copy_count++;
			end else begin
				copy_count = 0;
				if (replay_col + 1 < w) begin
					replay_col++;
				end else begin
					replay_col = 0;
					r.row_end = 1'b1;
					r.pad = 2'((4 - ((3 * w * s) % 4)) % 4);
					if (row_count + 1 < s) begin
						row_count++;
					end else begin
						row_count = 0;
						loaded_pixels = 0;
						r.group_end = 1'b1;
					end
				end
			end
			out_pixels_due.push_back(r);
		end
	endtask

	task automatic send_item(input cmd_t c, input logic [23:0] data);
		int unsigned gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(48, 200);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 8);
			end
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		replicate_step(c, data);
		burst_left--;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (out_pixels_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input bit set_scale, input logic [6:0] scale_val,
			input bit set_width, input logic [11:0] width_val);
		drain_results();
		if (set_scale) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= REG_SCALE_FACTOR;
			cfg_wdata <= {5'($urandom), scale_val};
			@(posedge clk);
			scale_reg = scale_val;
		end
		if (set_width) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= REG_ROW_WIDTH;
			cfg_wdata <= width_val;
			@(posedge clk);
			width_reg = width_val;
		end
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 40)
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_hold <= $urandom_range(16, 160);
		end else begin
			rx_hold <= rx_hold - 1;
		end
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:   m_tready <= (rx_hold % 7) < 3;
		endcase
	end

	always @(posedge clk) begin : result_check
		out_pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (out_pixels_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 40)
					$display("%0t: transaction expected none got tuser %0h tlast %0h tdata %0h",
						$time, m_tuser, m_tlast, m_tdata);
			end else begin
				want = out_pixels_due.pop_front();
				check_field("status", want.status, m_tuser);
				check_field("red", want.rgb[7:0], m_tdata[7:0]);
				check_field("green", want.rgb[15:8], m_tdata[15:8]);
				check_field("blue", want.rgb[23:16], m_tdata[23:16]);
				check_field("row_end", want.row_end, m_tlast);
				check_field("pad_bytes", want.pad, m_tdata[25:24]);
				check_field("group_end", want.group_end, m_tdata[26]);
				check_field("tdata fill", '0, m_tdata[31:27]);
			end
		end
	end

	task automatic test_pull_after_reset();
		send_item(CMD_PULL, 24'($urandom));
	endtask

	task automatic test_reset_geometry();
		send_item(CMD_PUSH, 24'hFFFFFF);
		send_item(CMD_PUSH, 24'h000000);
		send_item(CMD_PULL, 24'($urandom));
		send_item(CMD_PUSH, 24'h000000);
		send_item(CMD_PULL, 24'hFFFFFF);
	endtask

	task automatic test_zero_registers();
		configure(1'b1, 7'd0, 1'b1, 12'd0);
		send_item(CMD_PUSH, 24'($urandom));
		send_item(CMD_PULL, 24'($urandom));
		send_item(CMD_PULL, 24'($urandom));
	endtask

	task automatic test_registers_mid_row();
		configure(1'b1, 7'd2, 1'b1, 12'd2);
		repeat (2) send_item(CMD_PUSH, 24'($urandom));
		repeat (3) send_item(CMD_PULL, 24'($urandom));
		configure(1'b1, 7'd1, 1'b1, 12'd1);
		repeat (2) send_item(CMD_PULL, 24'($urandom));
	endtask

	task automatic test_max_scale();
		configure(1'b1, 7'd127, 1'b1, 12'd1);
		repeat (2) send_item(CMD_PUSH, 24'($urandom));
		repeat (MAX_SCALE_DEF + 1) send_item(CMD_PULL, 24'($urandom));
	endtask

	task automatic test_max_width();
		configure(1'b1, 7'd1, 1'b1, 12'hFFF);
		repeat (24) send_item(CMD_PUSH, 24'($urandom));
		repeat (2) send_item(CMD_PULL, 24'($urandom));
	endtask

	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned phase_len;
		int unsigned pick;
		logic [6:0]  sv;
		logic [11:0] wv;
		cmd_t        c;
		sent = 0;
		while (sent < 400) begin
			pick = $urandom_range(0, 9);
			sv = (pick == 0) ? 7'd0 : (pick == 1) ? 7'($urandom_range(5, 8)) :
				7'($urandom_range(1, 4));
			pick = $urandom_range(0, 19);
			wv = (pick < 2) ? 12'd0 : (pick < 5) ? 12'($urandom_range(13, 40)) :
				12'($urandom_range(1, 12));
			pick = $urandom_range(0, 2);
			configure(pick != 1, sv, pick != 0, wv);
			phase_len = $urandom_range(30, 110);
			repeat (phase_len) begin
				// mostly well-formed rows, some refused pushes and early pulls
				if (loaded_pixels < active_width())
					c = ($urandom_range(0, 9) == 0) ? CMD_PULL : CMD_PUSH;
				else
					c = ($urandom_range(0, 9) == 0) ? CMD_PUSH : CMD_PULL;
				send_item(c, 24'($urandom));
			end
			sent += phase_len;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pull_after_reset();
		test_reset_geometry();
		test_zero_registers();
		test_registers_mid_row();
		test_max_scale();
		test_max_width();
		test_random_traffic();
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#15_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

/* pixel_replicate_upscaler_top.f */
src/pru_pkg.sv
src/pixel_replicate_upscaler_top.sv
bench/pixel_replicate_upscaler_top_tb.sv
